/* src/lfps_pkg.sv */
// Shared types, codes and constants of the line follower PID steering block.
package lfps_pkg;

  // Request codes carried by in_req_type.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  // Drive mode codes of the result.
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_DRIVE = 2'd1;
  localparam logic [1:0] MODE_SPIN  = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_WINDOW    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_SPEED = 3'd7;
  localparam int unsigned CFG_DATA_W = 16;

  // Speed limits.
  localparam logic [6:0] SPEED_MAX      = 7'd100;
  localparam logic [6:0] BASE_SPEED_MIN = 7'd20;
  localparam logic [6:0] WORK_SPEED_RST = 7'd20;

  // Line position of each pattern of sensors that see the line, truncated toward zero.
  localparam logic signed [7:0] POS_TABLE [32] = '{
    8'sd0,   -8'sd64, -8'sd32, -8'sd48, 8'sd0,   -8'sd32, -8'sd16, -8'sd32,
    8'sd32,  -8'sd16, 8'sd0,   -8'sd21, 8'sd16,  -8'sd10, 8'sd0,   -8'sd16,
    8'sd64,  8'sd0,   8'sd16,  -8'sd10, 8'sd32,  8'sd0,   8'sd10,  -8'sd8,
    8'sd48,  8'sd10,  8'sd21,  8'sd0,   8'sd32,  8'sd8,   8'sd16,  8'sd0
  };

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_START,
    KIND_STOP,
    KIND_NONE
  } kind_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    kind_t              kind;
    logic               line_seen;
    logic signed [7:0]  pos;
    logic [15:0]        now_ms;
  } item_t;

  typedef struct packed {
    logic [11:0] prop_gain;
    logic [11:0] integ_gain;
    logic [11:0] deriv_gain;
    logic [9:0]  integral_limit;
    logic [6:0]  turn_limit;
    logic [6:0]  base_speed;
    logic [15:0] lost_window_ms;
    logic [6:0]  recovery_speed;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    prop_gain:      12'd307,
    integ_gain:     12'd8,
    deriv_gain:     12'd154,
    integral_limit: 10'd60,
    turn_limit:     7'd60,
    base_speed:     7'd20,
    lost_window_ms: 16'd400,
    recovery_speed: 7'd20
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_FIN
  } state_t;

endpackage

/* src/lfps_front.sv */
// Front end: decodes the request and works out the line position of each item.
module lfps_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [4:0]         in_sensor_bits,
  input  logic [15:0]        in_now_ms,
  output logic               push_valid,
  input  logic               push_ready,
  output lfps_pkg::item_t    push_item
);

  logic [4:0]      seen;
  lfps_pkg::kind_t kind;

  // Sensors are active low.
  assign seen = ~in_sensor_bits;

  always_comb begin
    unique case (in_req_type)
      lfps_pkg::REQ_TICK:  kind = lfps_pkg::KIND_TICK;
      lfps_pkg::REQ_START: kind = lfps_pkg::KIND_START;
      lfps_pkg::REQ_STOP:  kind = lfps_pkg::KIND_STOP;
      default:             kind = lfps_pkg::KIND_NONE;
    endcase
  end

  assign push_item.kind      = kind;
  assign push_item.line_seen = (seen != 5'd0);
  assign push_item.pos       = lfps_pkg::POS_TABLE[seen];
  assign push_item.now_ms    = in_now_ms;

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

/* src/lfps_fifo.sv */
// Small queue of classified items between the front end and the back end.
module lfps_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  lfps_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output lfps_pkg::item_t pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lfps_pkg::item_t  slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* src/lfps_back.sv */
// Back end: follower state, lost-line handling, sequential PID and the result register.
module lfps_back (
  input  logic               clk,
  input  logic               rst_n,
  input  lfps_pkg::cfg_t     cfg,
  input  logic               item_valid,
  output logic               item_ready,
  input  lfps_pkg::item_t    item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_drive_mode,
  output logic signed [7:0]  out_left_speed,
  output logic signed [7:0]  out_right_speed,
  output logic               out_spin_clockwise
);

  lfps_pkg::state_t state_r, state_nxt;

  // Follower state.
  logic               running_r, running_nxt;
  logic signed [10:0] es_r, es_nxt;
  logic signed [7:0]  prev_r, prev_nxt;
  logic signed [7:0]  last_pos_r, last_pos_nxt;
  logic signed [1:0]  last_dir_r, last_dir_nxt;
  logic               lost_r, lost_nxt;
  logic [15:0]        lost_start_r, lost_start_nxt;
  logic [6:0]         ws_r, ws_nxt;

  // PID working registers.
  logic signed [7:0]  e_r, e_nxt;
  logic signed [8:0]  d_r, d_nxt;
  logic signed [24:0] acc_r, acc_nxt;
  logic [1:0]         step_r, step_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic signed [7:0]  left_r, left_nxt;
  logic signed [7:0]  right_r, right_nxt;
  logic               cw_r, cw_nxt;

  logic               go, needs_pid;
  logic [6:0]         base_ld, recov_ld;
  logic [15:0]        start_eff, elapsed;
  logic               in_window;
  logic signed [8:0]  ext_sum;
  logic signed [7:0]  ext_pos;
  logic               sgn_chg;
  logic signed [10:0] es_base;
  logic signed [11:0] es_sum, ilim_s, es_clamp;
  logic [11:0]        gain_sel;
  logic signed [12:0] mul_a;
  logic signed [10:0] mul_b;
  logic signed [23:0] prod;
  logic signed [24:0] tl, acc_c, turn_w;
  logic signed [7:0]  turn;
  logic signed [9:0]  ws_s, turn_e, lsum, rsum;
  logic signed [7:0]  lsat, rsat;

  assign base_ld  = (cfg.base_speed < lfps_pkg::BASE_SPEED_MIN) ? lfps_pkg::BASE_SPEED_MIN :
                    (cfg.base_speed > lfps_pkg::SPEED_MAX) ? lfps_pkg::SPEED_MAX : cfg.base_speed;
  assign recov_ld = (cfg.recovery_speed > lfps_pkg::SPEED_MAX) ? lfps_pkg::SPEED_MAX
                                                              : cfg.recovery_speed;

  assign go         = (state_r == lfps_pkg::ST_IDLE) && item_valid && !out_valid_r;
  assign item_ready = go;

  // On the first tick without the line the loss starts now, so the elapsed time is zero.
  assign start_eff = lost_r ? lost_start_r : item.now_ms;
  assign elapsed   = item.now_ms - start_eff;
  assign in_window = (elapsed < cfg.lost_window_ms);

  assign needs_pid = (item.kind == lfps_pkg::KIND_TICK) && running_r
                     && (item.line_seen || in_window);

  // Extrapolated position while the line is lost.
  assign ext_sum = $signed({last_pos_r[7], last_pos_r})
                 + $signed({{4{last_dir_r[1]}}, last_dir_r, 3'b000});
  assign ext_pos = (ext_sum > 9'sd64) ? 8'sd64 :
                   (ext_sum < -9'sd64) ? -8'sd64 : ext_sum[7:0];

  // Integral update: cleared on a strict sign change, then accumulated and clamped.
  assign sgn_chg  = ((e_r > 8'sd0) && (prev_r < 8'sd0)) || ((e_r < 8'sd0) && (prev_r > 8'sd0));
  assign es_base  = sgn_chg ? 11'sd0 : es_r;
  assign es_sum   = $signed({es_base[10], es_base}) + $signed({{4{e_r[7]}}, e_r});
  assign ilim_s   = $signed({2'b00, cfg.integral_limit});
  assign es_clamp = (es_sum > ilim_s) ? ilim_s :
                    (es_sum < -ilim_s) ? -ilim_s : es_sum;

  // Shared multiplier, one gain term per step.
  always_comb begin
    case (step_r)
      2'd0: begin
        gain_sel = cfg.prop_gain;
        mul_b    = $signed({{3{e_r[7]}}, e_r});
      end
      2'd1: begin
        gain_sel = cfg.integ_gain;
        mul_b    = es_r;
      end
      default: begin
        gain_sel = cfg.deriv_gain;
        mul_b    = $signed({{2{d_r[8]}}, d_r});
      end
    endcase
  end

  assign mul_a = $signed({1'b0, gain_sel});
  assign prod  = mul_a * mul_b;

  // Turn: clamp to the turn limit in Q8.8, then truncate toward zero.
  assign tl     = $signed({10'b0, cfg.turn_limit, 8'b0});
  assign acc_c  = (acc_r > tl) ? tl : (acc_r < -tl) ? -tl : acc_r;
  assign turn_w = (acc_c >>> 8)
                + (((acc_c < 25'sd0) && (acc_c[7:0] != 8'd0)) ? 25'sd1 : 25'sd0);
  assign turn   = turn_w[7:0];

  assign ws_s   = $signed({3'b000, ws_r});
  assign turn_e = $signed({{2{turn[7]}}, turn});
  assign lsum   = ws_s - turn_e;
  assign rsum   = ws_s + turn_e;
  assign lsat   = (lsum > 10'sd100) ? 8'sd100 : (lsum < -10'sd100) ? -8'sd100 : lsum[7:0];
  assign rsat   = (rsum > 10'sd100) ? 8'sd100 : (rsum < -10'sd100) ? -8'sd100 : rsum[7:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfps_pkg::ST_IDLE: begin
        if (go && needs_pid) begin
          state_nxt = lfps_pkg::ST_PREP;
        end
      end
      lfps_pkg::ST_PREP: state_nxt = lfps_pkg::ST_MUL;
      lfps_pkg::ST_MUL: begin
        if (step_r == 2'd2) begin
          state_nxt = lfps_pkg::ST_FIN;
        end
      end
      lfps_pkg::ST_FIN: state_nxt = lfps_pkg::ST_IDLE;
      default: state_nxt = lfps_pkg::ST_IDLE;
    endcase
  end

  // Datapath and result.
  always_comb begin
    running_nxt    = running_r;
    es_nxt         = es_r;
    prev_nxt       = prev_r;
    last_pos_nxt   = last_pos_r;
    last_dir_nxt   = last_dir_r;
    lost_nxt       = lost_r;
    lost_start_nxt = lost_start_r;
    ws_nxt         = ws_r;
    e_nxt          = e_r;
    d_nxt          = d_r;
    acc_nxt        = acc_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    mode_nxt       = mode_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    cw_nxt         = cw_r;

    unique case (state_r)
      lfps_pkg::ST_IDLE: begin
        if (go) begin
          if (!needs_pid) begin
            out_valid_nxt = 1'b1;
            mode_nxt      = lfps_pkg::MODE_NONE;
            left_nxt      = 8'sd0;
            right_nxt     = 8'sd0;
            cw_nxt        = 1'b0;
          end
          unique case (item.kind)
            lfps_pkg::KIND_START: begin
              es_nxt       = 11'sd0;
              prev_nxt     = 8'sd0;
              last_pos_nxt = 8'sd0;
              last_dir_nxt = 2'sd0;
              lost_nxt     = 1'b0;
              ws_nxt       = base_ld;
              running_nxt  = 1'b1;
            end
            lfps_pkg::KIND_STOP: begin
              running_nxt = 1'b0;
              mode_nxt    = lfps_pkg::MODE_STOP;
            end
            lfps_pkg::KIND_TICK: begin
              if (running_r) begin
                if (!item.line_seen) begin
                  lost_nxt       = 1'b1;
                  lost_start_nxt = start_eff;
                  if (!lost_r) begin
                    es_nxt   = 11'sd0;
                    prev_nxt = 8'sd0;
                  end
                  if (in_window) begin
                    ws_nxt = recov_ld;
                    e_nxt  = -ext_pos;
                  end else begin
                    mode_nxt  = lfps_pkg::MODE_SPIN;
                    left_nxt  = $signed({1'b0, recov_ld});
                    right_nxt = $signed({1'b0, recov_ld});
                    cw_nxt    = !last_dir_r[1];
                  end
                end else begin
                  if (lost_r) begin
                    es_nxt   = 11'sd0;
                    prev_nxt = 8'sd0;
                    lost_nxt = 1'b0;
                    ws_nxt   = base_ld;
                  end
                  last_pos_nxt = item.pos;
                  if (item.pos > 8'sd4) begin
                    last_dir_nxt = 2'sd1;
                  end else if (item.pos < -8'sd4) begin
                    last_dir_nxt = -2'sd1;
                  end
                  e_nxt = -item.pos;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      lfps_pkg::ST_PREP: begin
        es_nxt   = es_clamp[10:0];
        d_nxt    = $signed({e_r[7], e_r}) - $signed({prev_r[7], prev_r});
        prev_nxt = e_r;
        acc_nxt  = 25'sd0;
        step_nxt = 2'd0;
      end
      lfps_pkg::ST_MUL: begin
        acc_nxt  = acc_r + $signed({prod[23], prod});
        step_nxt = step_r + 2'd1;
      end
      lfps_pkg::ST_FIN: begin
        out_valid_nxt = 1'b1;
        mode_nxt      = lfps_pkg::MODE_DRIVE;
        left_nxt      = lsat;
        right_nxt     = rsat;
        cw_nxt        = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lfps_pkg::ST_IDLE;
      running_r    <= 1'b0;
      es_r         <= 11'sd0;
      prev_r       <= 8'sd0;
      last_pos_r   <= 8'sd0;
      last_dir_r   <= 2'sd0;
      lost_r       <= 1'b0;
      lost_start_r <= 16'd0;
      ws_r         <= lfps_pkg::WORK_SPEED_RST;
      step_r       <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      running_r    <= running_nxt;
      es_r         <= es_nxt;
      prev_r       <= prev_nxt;
      last_pos_r   <= last_pos_nxt;
      last_dir_r   <= last_dir_nxt;
      lost_r       <= lost_nxt;
      lost_start_r <= lost_start_nxt;
      ws_r         <= ws_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r     <= e_nxt;
    d_r     <= d_nxt;
    acc_r   <= acc_nxt;
    mode_r  <= mode_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    cw_r    <= cw_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_drive_mode     = mode_r;
  assign out_left_speed     = left_r;
  assign out_right_speed    = right_r;
  assign out_spin_clockwise = cw_r;

endmodule

/* src/line_follow_pid_steering.sv */
// Top level of the five-sensor line follower with PID differential steering.
//
//  Channel  Handshake            Payload
//  -------  -------------------  ---------------------------------------------------
//  in       in_valid/in_ready    in_req_type, in_sensor_bits, in_now_ms
//  out      out_valid/out_ready  out_drive_mode, out_left_speed, out_right_speed,
//                                out_spin_clockwise
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Start, stop, ignored and spin items are settled and registered from the idle state of
// the back end. A tick that runs the PID goes through the decision, the integral update,
// one step for each of the three gain products on the shared multiplier, then clamping
// and wheel speeds. The back end takes its next item only once it is idle again and its
// result has been accepted.
// Reset is synchronous and active low; it loads the register defaults and clears the
// follower state. There is no clearing pass, so the block is ready right after reset.
// The queue of QUEUE_DEPTH items lets the front end keep accepting while the back end
// works, and the back end holds at most one result, waiting while out_ready is low.
module line_follow_pid_steering #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_req_type,
  input  logic [4:0]                           in_sensor_bits,
  input  logic [15:0]                          in_now_ms,

  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_drive_mode,
  output logic signed [7:0]                    out_left_speed,
  output logic signed [7:0]                    out_right_speed,
  output logic                                 out_spin_clockwise,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]      cfg_data
);

  lfps_pkg::cfg_t  cfg_r;
  lfps_pkg::item_t push_item, pop_item;
  logic            push_valid, push_ready;
  logic            pop_valid, pop_ready;

  // Register writes are always taken; each register keeps the low bits of the data.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lfps_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lfps_pkg::REG_PROP_GAIN:      cfg_r.prop_gain      <= cfg_data[11:0];
        lfps_pkg::REG_INTEG_GAIN:     cfg_r.integ_gain     <= cfg_data[11:0];
        lfps_pkg::REG_DERIV_GAIN:     cfg_r.deriv_gain     <= cfg_data[11:0];
        lfps_pkg::REG_INTEGRAL_LIMIT: cfg_r.integral_limit <= cfg_data[9:0];
        lfps_pkg::REG_TURN_LIMIT:     cfg_r.turn_limit     <= cfg_data[6:0];
        lfps_pkg::REG_BASE_SPEED:     cfg_r.base_speed     <= cfg_data[6:0];
        lfps_pkg::REG_LOST_WINDOW:    cfg_r.lost_window_ms <= cfg_data[15:0];
        lfps_pkg::REG_RECOVERY_SPEED: cfg_r.recovery_speed <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // The front end decodes the request and looks up the line position from the sensors.
  lfps_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_sensor_bits (in_sensor_bits),
    .in_now_ms      (in_now_ms),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  // Classified items wait here until the back end is free.
  lfps_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // The back end owns the follower state, runs the PID and holds the result.
  lfps_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .item_valid         (pop_valid),
    .item_ready         (pop_ready),
    .item               (pop_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_drive_mode     (out_drive_mode),
    .out_left_speed     (out_left_speed),
    .out_right_speed    (out_right_speed),
    .out_spin_clockwise (out_spin_clockwise)
  );

endmodule
